// File: hdl/tks_pkg.sv
// Package for the top-k triple sum selector: command and status codes,
// controller states, datapath operations and the control/status structs.
// No dependencies.
package tks_pkg;

  localparam logic [2:0] CMD_LOAD_A = 3'd0;
  localparam logic [2:0] CMD_LOAD_B = 3'd1;
  localparam logic [2:0] CMD_LOAD_C = 3'd2;
  localparam logic [2:0] CMD_NEXT   = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_FULL  = 3'd1;
  localparam logic [2:0] ST_EMPTY = 3'd2;
  localparam logic [2:0] ST_OVF   = 3'd3;
  localparam logic [2:0] ST_IGN   = 3'd4;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_LD_CHK, S_INS, S_NX_START, S_RDTOP, S_TAKETOP,
    S_TAKELAST, S_SD_L, S_SD_R, S_SD_CMP, S_NB_SEL, S_NB_CHK, S_SU,
    S_SU_CMP, S_EMIT, S_CLRCMD
  } ctl_state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_INS, OP_SEED, OP_RDTOP, OP_TAKETOP, OP_TAKELAST,
    OP_SDL, OP_SDR, OP_SDCMP, OP_NBSEL, OP_NBCHK, OP_SU, OP_SUCMP,
    OP_EMIT, OP_CLEAR, OP_CLRSTEP
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] code;
  } dp_cmd_t;

  typedef struct packed {
    logic started;
    logic any_empty;
    logic heap_empty;
    logic heap_full;
    logic ld_bad;
    logic ins_done;
    logic sd_end;
    logic sd_stop;
    logic nb_in;
    logic nb_last;
    logic seen;
    logic su_root;
    logic su_stop;
    logic clr_last;
  } dp_stat_t;

endpackage

// File: hdl/tks_if.sv
// Word channel interfaces for the top-k triple sum selector.
// Depends on nothing.
interface tks_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [39:0] value;
  modport source (output valid, output cmd, output value, input ready);
  modport sink (input valid, input cmd, input value, output ready);
endinterface

interface tks_out_if;
  logic        valid;
  logic        ready;
  logic [41:0] sum;
  logic [2:0]  status;
  modport source (output valid, output sum, output status, input ready);
  modport sink (input valid, input sum, input status, output ready);
endinterface

// File: hdl/top_k_triple_sum_select_core.sv
// Top level of the top-k triple sum selector: controller plus datapath.
// Depends on tks_pkg, tks_if, tks_controller, tks_datapath.
//
// Usage: req carries one command word (cmd, value); rsp returns exactly one
// word (sum, status) per command. Commands load lists A/B/C (kept sorted
// descending), fetch the next largest A[i]+B[j]+C[k], or clear the block.
// One command is in flight at a time; req.ready is high only when the
// controller is idle and the result register is free or being drained.
// A load shifts smaller entries down one at a time before inserting. A next pops
// the heap top, sifts the last entry down, then pushes each unvisited in-range
// neighbor with a sift-up (single port heap memory) before the result is emitted.
// Reset and the clear command both start a clearing pass over the visited
// bitmap (A_DEPTH*B_DEPTH*C_DEPTH entries, 4096 by default) during which
// no command is accepted; clear returns its word before the pass.
// A stalled rsp holds its word and blocks the next command.
module top_k_triple_sum_select_core #(
  parameter int A_DEPTH    = 16,
  parameter int B_DEPTH    = 16,
  parameter int C_DEPTH    = 16,
  parameter int HEAP_DEPTH = 256,
  parameter int VALUE_BITS = 40
) (
  input  logic      clk,
  input  logic      rst,
  tks_in_if.sink    req,
  tks_out_if.source rsp
);

  tks_pkg::dp_cmd_t  dcmd;
  tks_pkg::dp_stat_t stat;

  tks_controller u_ctl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_cmd   (req.cmd),
    .out_busy (rsp.valid && !rsp.ready),
    .stat     (stat),
    .in_ready (req.ready),
    .dcmd     (dcmd)
  );

  tks_datapath #(
    .A_DEPTH    (A_DEPTH),
    .B_DEPTH    (B_DEPTH),
    .C_DEPTH    (C_DEPTH),
    .HEAP_DEPTH (HEAP_DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .dcmd       (dcmd),
    .in_cmd     (req.cmd),
    .in_value   (req.value),
    .out_ready  (rsp.ready),
    .stat       (stat),
    .out_valid  (rsp.valid),
    .out_sum    (rsp.sum),
    .out_status (rsp.status)
  );

endmodule

// File: hdl/tks_datapath.sv
// Datapath: sorted lists, candidate heap memory, visited bitmap, result register.
// Depends on tks_pkg.
module tks_datapath #(
  parameter int A_DEPTH    = 16,
  parameter int B_DEPTH    = 16,
  parameter int C_DEPTH    = 16,
  parameter int HEAP_DEPTH = 256,
  parameter int VALUE_BITS = 40
) (
  input  logic             clk,
  input  logic             rst,
  input  tks_pkg::dp_cmd_t dcmd,
  input  logic [2:0]       in_cmd,
  input  logic [39:0]      in_value,
  input  logic             out_ready,
  output tks_pkg::dp_stat_t stat,
  output logic             out_valid,
  output logic [41:0]      out_sum,
  output logic [2:0]       out_status
);

  localparam int VW  = VALUE_BITS;
  localparam int SW  = VW + 2;
  localparam int AIW = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
  localparam int BIW = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
  localparam int CIW = (C_DEPTH > 1) ? $clog2(C_DEPTH) : 1;
  localparam int ACW = $clog2(A_DEPTH + 1);
  localparam int BCW = $clog2(B_DEPTH + 1);
  localparam int CCW = $clog2(C_DEPTH + 1);
  localparam int MCW = (ACW > BCW) ? ((ACW > CCW) ? ACW : CCW) : ((BCW > CCW) ? BCW : CCW);
  localparam int HAW = $clog2(HEAP_DEPTH);
  localparam int HSW = $clog2(HEAP_DEPTH + 1);
  localparam int PW  = HAW + 2;
  localparam int VN  = A_DEPTH * B_DEPTH * C_DEPTH;
  localparam int VIW = (VN > 1) ? $clog2(VN) : 1;
  localparam int IXW = AIW + BIW + CIW;
  localparam int EW  = SW + IXW;

  logic [VW-1:0]  la [A_DEPTH];
  logic [VW-1:0]  lb [B_DEPTH];
  logic [VW-1:0]  lc [C_DEPTH];
  logic [ACW-1:0] cnt_a;
  logic [BCW-1:0] cnt_b;
  logic [CCW-1:0] cnt_c;
  logic [2:0]     lsel;
  logic [MCW-1:0] ins_p;
  logic [VW-1:0]  ins_v;
  logic [AIW-1:0] pi;
  logic [BIW-1:0] pj;
  logic [CIW-1:0] pk;
  logic           started;

  logic [EW-1:0]  hmem [HEAP_DEPTH];
  logic [EW-1:0]  hq;
  logic [HSW-1:0] hsize;
  logic [EW-1:0]  top, last, lch, cand;
  logic [HAW-1:0] pos;
  logic           vmem [VN];
  logic           vq;
  logic [VIW-1:0] vaddr;
  logic [VIW-1:0] clr_cnt;
  logic [1:0]     nb;
  logic           ovf;
  logic [SW-1:0]  res_sum;

  logic           hwe, vwe, vwd;
  logic [HAW-1:0] hwa, hra;
  logic [EW-1:0]  hwd;
  logic [VIW-1:0] vwa, vra;

  logic [AIW-1:0] ra_addr;
  logic [BIW-1:0] rb_addr;
  logic [CIW-1:0] rc_addr;
  logic [VW-1:0]  ra, rb, rc, lrd;
  logic           ins_move;
  logic [SW-1:0]  psum;

  logic [SW-1:0]  hq_s, lch_s, last_s, cand_s, big_s;
  logic [AIW-1:0] ti;
  logic [BIW-1:0] tj;
  logic [CIW-1:0] tk;
  logic [PW-1:0]  lx, rx;
  logic           r_ok, big_r;
  logic [EW-1:0]  big;
  logic [HAW-1:0] bidx, par;
  logic [ACW-1:0] ni;
  logic [BCW-1:0] nj;
  logic [CCW-1:0] nk;
  logic [AIW-1:0] nbi;
  logic [BIW-1:0] nbj;
  logic [CIW-1:0] nbk;
  logic [VIW-1:0] nv;
  logic           nb_in;

  assign hq_s   = hq[EW-1 -: SW];
  assign lch_s  = lch[EW-1 -: SW];
  assign last_s = last[EW-1 -: SW];
  assign cand_s = cand[EW-1 -: SW];
  assign ti     = top[IXW-1 -: AIW];
  assign tj     = top[BIW+CIW-1 -: BIW];
  assign tk     = top[CIW-1:0];

  // list read ports: insertion scan or probe triple
  assign ra_addr = (dcmd.op == tks_pkg::OP_INS) ? AIW'(ins_p - MCW'(1)) : pi;
  assign rb_addr = (dcmd.op == tks_pkg::OP_INS) ? BIW'(ins_p - MCW'(1)) : pj;
  assign rc_addr = (dcmd.op == tks_pkg::OP_INS) ? CIW'(ins_p - MCW'(1)) : pk;
  assign ra = la[ra_addr];
  assign rb = lb[rb_addr];
  assign rc = lc[rc_addr];
  assign psum = SW'(ra) + SW'(rb) + SW'(rc);

  always_comb begin
    case (lsel)
      tks_pkg::CMD_LOAD_A: lrd = ra;
      tks_pkg::CMD_LOAD_B: lrd = rb;
      default:             lrd = rc;
    endcase
  end
  assign ins_move = (ins_p != '0) && (lrd < ins_v);

  // sift-down child selection
  assign lx    = (PW'(pos) << 1) + PW'(1);
  assign rx    = lx + PW'(1);
  assign r_ok  = rx < PW'(hsize);
  assign big_r = r_ok && (lch_s < hq_s);
  assign big   = big_r ? hq : lch;
  assign big_s = big[EW-1 -: SW];
  assign bidx  = big_r ? HAW'(rx) : HAW'(lx);
  assign par   = (pos - HAW'(1)) >> 1;

  // neighbor triple
  assign ni = ACW'(ti) + ACW'(1);
  assign nj = BCW'(tj) + BCW'(1);
  assign nk = CCW'(tk) + CCW'(1);
  always_comb begin
    nbi = ti;
    nbj = tj;
    nbk = tk;
    nb_in = 1'b0;
    case (nb)
      2'd0: begin
        nbi = AIW'(ni);
        nb_in = ni < cnt_a;
      end
      2'd1: begin
        nbj = BIW'(nj);
        nb_in = nj < cnt_b;
      end
      default: begin
        nbk = CIW'(nk);
        nb_in = nk < cnt_c;
      end
    endcase
  end
  assign nv = VIW'((VIW'(nbi) * VIW'(B_DEPTH) + VIW'(nbj)) * VIW'(C_DEPTH) + VIW'(nbk));

  always_comb begin
    stat.started    = started;
    stat.any_empty  = (cnt_a == '0) || (cnt_b == '0) || (cnt_c == '0);
    stat.heap_empty = hsize == '0;
    stat.heap_full  = hsize == HSW'(HEAP_DEPTH);
    case (lsel)
      tks_pkg::CMD_LOAD_A: stat.ld_bad = started || (cnt_a == ACW'(A_DEPTH));
      tks_pkg::CMD_LOAD_B: stat.ld_bad = started || (cnt_b == BCW'(B_DEPTH));
      default:             stat.ld_bad = started || (cnt_c == CCW'(C_DEPTH));
    endcase
    stat.ins_done = !ins_move;
    stat.sd_end   = lx >= PW'(hsize);
    stat.sd_stop  = !(last_s < big_s);
    stat.nb_in    = nb_in;
    stat.nb_last  = nb == 2'd2;
    stat.seen     = vq;
    stat.su_root  = pos == '0;
    stat.su_stop  = !(hq_s < cand_s);
    stat.clr_last = clr_cnt == VIW'(VN - 1);
  end

  // memory port controls
  always_comb begin
    hwe = 1'b0;
    hwa = pos;
    hwd = last;
    hra = '0;
    vwe = 1'b0;
    vwa = vaddr;
    vwd = 1'b1;
    vra = nv;
    case (dcmd.op)
      tks_pkg::OP_SEED: begin
        hwe = 1'b1;
        hwa = '0;
        hwd = {psum, {IXW{1'b0}}};
        vwe = 1'b1;
        vwa = '0;
      end
      tks_pkg::OP_TAKETOP: hra = HAW'(hsize);
      tks_pkg::OP_SDL: begin
        hwe = stat.sd_end;
        hra = HAW'(lx);
      end
      tks_pkg::OP_SDR: hra = HAW'(rx);
      tks_pkg::OP_SDCMP: begin
        hwe = 1'b1;
        hwd = stat.sd_stop ? last : big;
      end
      tks_pkg::OP_NBCHK: vwe = !vq && !stat.heap_full;
      tks_pkg::OP_SU: begin
        hwe = stat.su_root;
        hwa = '0;
        hwd = cand;
        hra = par;
      end
      tks_pkg::OP_SUCMP: begin
        hwe = 1'b1;
        hwd = stat.su_stop ? cand : hq;
      end
      tks_pkg::OP_CLRSTEP: begin
        vwe = 1'b1;
        vwa = clr_cnt;
        vwd = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (hwe) hmem[hwa] <= hwd;
    hq <= hmem[hra];
  end

  always_ff @(posedge clk) begin
    if (vwe) vmem[vwa] <= vwd;
    vq <= vmem[vra];
  end

  // list storage
  always_ff @(posedge clk) begin
    if (dcmd.op == tks_pkg::OP_INS) begin
      case (lsel)
        tks_pkg::CMD_LOAD_A: la[AIW'(ins_p)] <= ins_move ? lrd : ins_v;
        tks_pkg::CMD_LOAD_B: lb[BIW'(ins_p)] <= ins_move ? lrd : ins_v;
        default:             lc[CIW'(ins_p)] <= ins_move ? lrd : ins_v;
      endcase
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dcmd.op == tks_pkg::OP_EMIT || dcmd.op == tks_pkg::OP_CLEAR) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_a     <= '0;
      cnt_b     <= '0;
      cnt_c     <= '0;
      hsize     <= '0;
      started   <= 1'b0;
      clr_cnt   <= '0;
    end else begin
      case (dcmd.op)
        tks_pkg::OP_INS: begin
          if (!ins_move) begin
            case (lsel)
              tks_pkg::CMD_LOAD_A: cnt_a <= cnt_a + ACW'(1);
              tks_pkg::CMD_LOAD_B: cnt_b <= cnt_b + BCW'(1);
              default:             cnt_c <= cnt_c + CCW'(1);
            endcase
          end
        end
        tks_pkg::OP_SEED: begin
          started <= 1'b1;
          hsize   <= HSW'(1);
        end
        tks_pkg::OP_RDTOP: hsize <= hsize - HSW'(1);
        tks_pkg::OP_NBCHK: if (!vq && !stat.heap_full) hsize <= hsize + HSW'(1);
        tks_pkg::OP_CLEAR: begin
          cnt_a     <= '0;
          cnt_b     <= '0;
          cnt_c     <= '0;
          hsize     <= '0;
          started   <= 1'b0;
          clr_cnt   <= '0;
        end
        tks_pkg::OP_CLRSTEP: clr_cnt <= clr_cnt + VIW'(1);
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (dcmd.op)
      tks_pkg::OP_ACCEPT: begin
        lsel    <= in_cmd;
        ins_v   <= VW'(in_value);
        case (in_cmd)
          tks_pkg::CMD_LOAD_A: ins_p <= MCW'(cnt_a);
          tks_pkg::CMD_LOAD_B: ins_p <= MCW'(cnt_b);
          default:             ins_p <= MCW'(cnt_c);
        endcase
        pi      <= '0;
        pj      <= '0;
        pk      <= '0;
        ovf     <= 1'b0;
        res_sum <= '0;
      end
      tks_pkg::OP_INS: if (ins_move) ins_p <= ins_p - MCW'(1);
      tks_pkg::OP_TAKETOP: begin
        top     <= hq;
        res_sum <= hq_s;
        nb      <= 2'd0;
      end
      tks_pkg::OP_TAKELAST: begin
        last <= hq;
        pos  <= '0;
      end
      tks_pkg::OP_SDR: lch <= hq;
      tks_pkg::OP_SDCMP: if (!stat.sd_stop) pos <= bidx;
      tks_pkg::OP_NBSEL: begin
        if (stat.nb_in) begin
          pi    <= nbi;
          pj    <= nbj;
          pk    <= nbk;
          vaddr <= nv;
        end else begin
          nb <= nb + 2'd1;
        end
      end
      tks_pkg::OP_NBCHK: begin
        if (vq) begin
          nb <= nb + 2'd1;
        end else if (stat.heap_full) begin
          ovf <= 1'b1;
          nb  <= nb + 2'd1;
        end else begin
          cand <= {psum, pi, pj, pk};
          pos  <= HAW'(hsize);
        end
      end
      tks_pkg::OP_SU: if (stat.su_root) nb <= nb + 2'd1;
      tks_pkg::OP_SUCMP: begin
        if (stat.su_stop) nb <= nb + 2'd1;
        else pos <= par;
      end
      tks_pkg::OP_EMIT: begin
        out_sum    <= 42'(res_sum);
        out_status <= (dcmd.code == tks_pkg::ST_OK && ovf) ? tks_pkg::ST_OVF : dcmd.code;
      end
      tks_pkg::OP_CLEAR: begin
        out_sum    <= '0;
        out_status <= tks_pkg::ST_OK;
      end
      default: ;
    endcase
  end

endmodule

// File: hdl/tks_controller.sv
// Controller FSM: sequences loads, heap pop, sift passes, neighbor pushes and clearing.
// Depends on tks_pkg.
module tks_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [2:0]         in_cmd,
  input  logic               out_busy,
  input  tks_pkg::dp_stat_t  stat,
  output logic               in_ready,
  output tks_pkg::dp_cmd_t   dcmd
);

  tks_pkg::ctl_state_t state, state_next;
  logic [2:0]          code, code_next;
  logic                fire;

  assign in_ready = (state == tks_pkg::S_IDLE) && !out_busy;
  assign fire     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tks_pkg::S_CLR;
      code  <= tks_pkg::ST_OK;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

  always_comb begin
    state_next = state;
    code_next  = code;
    case (state)
      tks_pkg::S_CLR: if (stat.clr_last) state_next = tks_pkg::S_IDLE;
      tks_pkg::S_IDLE: begin
        if (fire) begin
          case (in_cmd)
            tks_pkg::CMD_LOAD_A, tks_pkg::CMD_LOAD_B, tks_pkg::CMD_LOAD_C:
              state_next = tks_pkg::S_LD_CHK;
            tks_pkg::CMD_NEXT:  state_next = tks_pkg::S_NX_START;
            tks_pkg::CMD_CLEAR: state_next = tks_pkg::S_CLRCMD;
            default: begin
              code_next  = tks_pkg::ST_IGN;
              state_next = tks_pkg::S_EMIT;
            end
          endcase
        end
      end
      tks_pkg::S_LD_CHK: begin
        if (stat.ld_bad) begin
          code_next  = tks_pkg::ST_FULL;
          state_next = tks_pkg::S_EMIT;
        end else begin
          state_next = tks_pkg::S_INS;
        end
      end
      tks_pkg::S_INS: begin
        if (stat.ins_done) begin
          code_next  = tks_pkg::ST_OK;
          state_next = tks_pkg::S_EMIT;
        end
      end
      tks_pkg::S_NX_START: begin
        if ((!stat.started && stat.any_empty) || (stat.started && stat.heap_empty)) begin
          code_next  = tks_pkg::ST_EMPTY;
          state_next = tks_pkg::S_EMIT;
        end else begin
          state_next = tks_pkg::S_RDTOP;
        end
      end
      tks_pkg::S_RDTOP: state_next = tks_pkg::S_TAKETOP;
      tks_pkg::S_TAKETOP:
        state_next = stat.heap_empty ? tks_pkg::S_NB_SEL : tks_pkg::S_TAKELAST;
      tks_pkg::S_TAKELAST: state_next = tks_pkg::S_SD_L;
      tks_pkg::S_SD_L: state_next = stat.sd_end ? tks_pkg::S_NB_SEL : tks_pkg::S_SD_R;
      tks_pkg::S_SD_R: state_next = tks_pkg::S_SD_CMP;
      tks_pkg::S_SD_CMP: state_next = stat.sd_stop ? tks_pkg::S_NB_SEL : tks_pkg::S_SD_L;
      tks_pkg::S_NB_SEL: begin
        code_next = tks_pkg::ST_OK;
        if (stat.nb_in) state_next = tks_pkg::S_NB_CHK;
        else if (stat.nb_last) state_next = tks_pkg::S_EMIT;
      end
      tks_pkg::S_NB_CHK: begin
        if (stat.seen || stat.heap_full)
          state_next = stat.nb_last ? tks_pkg::S_EMIT : tks_pkg::S_NB_SEL;
        else
          state_next = tks_pkg::S_SU;
      end
      tks_pkg::S_SU: begin
        if (stat.su_root) state_next = stat.nb_last ? tks_pkg::S_EMIT : tks_pkg::S_NB_SEL;
        else state_next = tks_pkg::S_SU_CMP;
      end
      tks_pkg::S_SU_CMP: begin
        if (stat.su_stop) state_next = stat.nb_last ? tks_pkg::S_EMIT : tks_pkg::S_NB_SEL;
        else state_next = tks_pkg::S_SU;
      end
      tks_pkg::S_EMIT:   state_next = tks_pkg::S_IDLE;
      tks_pkg::S_CLRCMD: state_next = tks_pkg::S_CLR;
      default:           state_next = tks_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    dcmd.code = code;
    case (state)
      tks_pkg::S_CLR:      dcmd.op = tks_pkg::OP_CLRSTEP;
      tks_pkg::S_IDLE:     dcmd.op = fire ? tks_pkg::OP_ACCEPT : tks_pkg::OP_NONE;
      tks_pkg::S_INS:      dcmd.op = tks_pkg::OP_INS;
      tks_pkg::S_NX_START:
        dcmd.op = (!stat.started && !stat.any_empty) ? tks_pkg::OP_SEED : tks_pkg::OP_NONE;
      tks_pkg::S_RDTOP:    dcmd.op = tks_pkg::OP_RDTOP;
      tks_pkg::S_TAKETOP:  dcmd.op = tks_pkg::OP_TAKETOP;
      tks_pkg::S_TAKELAST: dcmd.op = tks_pkg::OP_TAKELAST;
      tks_pkg::S_SD_L:     dcmd.op = tks_pkg::OP_SDL;
      tks_pkg::S_SD_R:     dcmd.op = tks_pkg::OP_SDR;
      tks_pkg::S_SD_CMP:   dcmd.op = tks_pkg::OP_SDCMP;
      tks_pkg::S_NB_SEL:   dcmd.op = tks_pkg::OP_NBSEL;
      tks_pkg::S_NB_CHK:   dcmd.op = tks_pkg::OP_NBCHK;
      tks_pkg::S_SU:       dcmd.op = tks_pkg::OP_SU;
      tks_pkg::S_SU_CMP:   dcmd.op = tks_pkg::OP_SUCMP;
      tks_pkg::S_EMIT:     dcmd.op = tks_pkg::OP_EMIT;
      tks_pkg::S_CLRCMD:   dcmd.op = tks_pkg::OP_CLEAR;
      default:             dcmd.op = tks_pkg::OP_NONE;
    endcase
  end

endmodule

// File: sim/tb_top.sv
// Testbench for top_k_triple_sum_select_core: drives command words with bursty
// timing and checks every result word against a built-in predictor.
// Depends on tks_pkg, tks_if and the RTL top level.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [41:0] sum;
    logic [2:0]  status;
  } sum_word_t;

  class sum_scoreboard;
    logic [39:0] la[16];
    logic [39:0] lb[16];
    logic [39:0] lc[16];
    int na, nb, nc;
    logic [41:0] hsum[256];
    int hi[256], hj[256], hk[256];
    int hsize;
    bit visited[4096];
    bit started;
    sum_word_t due[$];
    int errors;

    function void clear_all();
      na = 0; nb = 0; nc = 0; hsize = 0; started = 0;
      foreach (visited[n]) visited[n] = 0;
    endfunction

    function void add_due(sum_word_t w);
      due = {due, w};
    endfunction

    function logic [2:0] insert(ref logic [39:0] l[16], ref int n, input logic [39:0] v);
      int p;
      if (started || n >= 16) return tks_pkg::ST_FULL;
      p = n;
      while (p > 0 && l[p-1] < v) begin
        l[p] = l[p-1];
        p--;
      end
      l[p] = v;
      n++;
      return tks_pkg::ST_OK;
    endfunction

    function bit push(int i, int j, int k);
      int pos, par;
      logic [41:0] s;
      if (hsize >= 256) return 0;
      s = {2'b0, la[i]} + {2'b0, lb[j]} + {2'b0, lc[k]};
      pos = hsize++;
      while (pos > 0) begin
        par = (pos - 1) / 2;
        if (!(hsum[par] < s)) break;
        hsum[pos] = hsum[par]; hi[pos] = hi[par]; hj[pos] = hj[par]; hk[pos] = hk[par];
        pos = par;
      end
      hsum[pos] = s; hi[pos] = i; hj[pos] = j; hk[pos] = k;
      return 1;
    endfunction

    function void pop(output logic [41:0] s, output int i, output int j, output int k);
      int pos, l, r, big, li, lj, lk;
      logic [41:0] ls;
      s = hsum[0]; i = hi[0]; j = hj[0]; k = hk[0];
      hsize--;
      if (hsize == 0) return;
      ls = hsum[hsize]; li = hi[hsize]; lj = hj[hsize]; lk = hk[hsize];
      pos = 0;
      forever begin
        l = 2 * pos + 1;
        r = l + 1;
        if (l >= hsize) break;
        big = l;
        if (r < hsize && hsum[l] < hsum[r]) big = r;
        if (!(ls < hsum[big])) break;
        hsum[pos] = hsum[big]; hi[pos] = hi[big]; hj[pos] = hj[big]; hk[pos] = hk[big];
        pos = big;
      end
      hsum[pos] = ls; hi[pos] = li; hj[pos] = lj; hk[pos] = lk;
    endfunction

    function bit try_next(int i, int j, int k);
      int n;
      n = (i * 16 + j) * 16 + k;
      if (visited[n]) return 1;
      if (!push(i, j, k)) return 0;
      visited[n] = 1;
      return 1;
    endfunction

    function void note(logic [2:0] cmd, logic [39:0] v);
      sum_word_t w;
      int i, j, k;
      bit ok;
      w.sum = '0;
      w.status = tks_pkg::ST_OK;
      case (cmd)
        tks_pkg::CMD_LOAD_A: w.status = insert(la, na, v);
        tks_pkg::CMD_LOAD_B: w.status = insert(lb, nb, v);
        tks_pkg::CMD_LOAD_C: w.status = insert(lc, nc, v);
        tks_pkg::CMD_NEXT: begin
          if (!started) begin
            if (na == 0 || nb == 0 || nc == 0) w.status = tks_pkg::ST_EMPTY;
            else begin
              started = 1;
              void'(push(0, 0, 0));
              visited[0] = 1;
            end
          end
          if (w.status == tks_pkg::ST_OK) begin
            if (hsize == 0) w.status = tks_pkg::ST_EMPTY;
            else begin
              pop(w.sum, i, j, k);
              ok = 1;
              if (i + 1 < na) ok = try_next(i + 1, j, k) && ok;
              if (j + 1 < nb) ok = try_next(i, j + 1, k) && ok;
              if (k + 1 < nc) ok = try_next(i, j, k + 1) && ok;
              if (!ok) w.status = tks_pkg::ST_OVF;
            end
          end
        end
        tks_pkg::CMD_CLEAR: clear_all();
        default: w.status = tks_pkg::ST_IGN;
      endcase
      add_due(w);
    endfunction

    task report(string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check(logic [41:0] s, logic [2:0] st);
      sum_word_t w;
      if (due.size() == 0) begin
        report($sformatf("unexpected word sum=%0d status=%0d", s, st));
        return;
      end
      w = due.pop_front();
      if (s !== w.sum) report($sformatf("sum %0d, want %0d", s, w.sum));
      if (st !== w.status) report($sformatf("status %0d, want %0d", st, w.status));
    endtask
  endclass

  logic clk, rst;
  tks_in_if req();
  tks_out_if rsp();
  sum_scoreboard sb;
  int sent, burst_left, rx_words;
  bit held_off;

  top_k_triple_sum_select_core uut (.clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source));

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("*** FAILED ***");
    $finish;
  end

  // accepted words on both sides
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      sb.check(rsp.sum, rsp.status);
      rx_words++;
    end
    if (!rst && req.valid && req.ready) sb.note(req.cmd, req.value);
  end

  // receiver stall pattern, with one long hold-off
  initial begin
    int hold, mode, left;
    hold = 0; mode = 0; left = 0;
    rsp.ready = 0;
    forever begin
      @(negedge clk);
      if (!held_off && rx_words >= 150) begin
        held_off = 1;
        hold = 500;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(10, 80);
      end
      left--;
      if (hold > 0) begin
        hold--;
        rsp.ready = 0;
      end else if (mode == 0) rsp.ready = 1;
      else if (mode == 1) rsp.ready = $urandom_range(0, 1);
      else rsp.ready = ($urandom_range(0, 7) != 0);
    end
  end

  task send(logic [2:0] cmd, logic [39:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      req.valid = 0;
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    req.valid = 1;
    req.cmd = cmd;
    req.value = v;
    do @(posedge clk); while (!req.ready);
    sent++;
    @(negedge clk);
    req.valid = 0;
  endtask

  task drain();
    while (sb.due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function logic [39:0] rand_val(int kind);
    case (kind)
      0: return 40'({$urandom, $urandom});
      1: return 40'($urandom_range(0, 5));
      default: return $urandom_range(0, 1) ? 40'hFF_FFFF_FFFF : 40'h0;
    endcase
  endfunction

  task load_list(logic [2:0] cmd, int n, int kind);
    repeat (n) send(cmd, rand_val(kind));
  endtask

  initial begin
    int na, nb, nc, nn, kind, prod;
    sb = new();
    sb.clear_all();
    req.valid = 0; req.cmd = tks_pkg::CMD_NEXT; req.value = '0;
    burst_left = 0; sent = 0; rx_words = 0; held_off = 0;
    rst = 1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    send(tks_pkg::CMD_NEXT, '0);
    send(3'd5, 40'hFF_FFFF_FFFF);
    send(3'd6, '0);
    send(3'd7, 40'h55_5555_5555);
    send(tks_pkg::CMD_LOAD_A, 40'hFF_FFFF_FFFF);
    send(tks_pkg::CMD_LOAD_A, 40'h0);
    send(tks_pkg::CMD_LOAD_B, 40'hAA_AAAA_AAAA);
    send(tks_pkg::CMD_LOAD_B, 40'hFF_FFFF_FFFF);
    send(tks_pkg::CMD_NEXT, '0);
    send(tks_pkg::CMD_LOAD_C, 40'hFF_FFFF_FFFF);
    send(tks_pkg::CMD_LOAD_C, 40'h1);
    repeat (3) send(tks_pkg::CMD_NEXT, '0);
    send(tks_pkg::CMD_LOAD_A, 40'h12_3456_789A);
    repeat (6) send(tks_pkg::CMD_NEXT, '0);
    drain();
    send(tks_pkg::CMD_CLEAR, 40'hFF_FFFF_FFFF);

    // small values (0 to 5) across full stores, to stress ties and heap depth
    load_list(tks_pkg::CMD_LOAD_A, 17, 1);
    load_list(tks_pkg::CMD_LOAD_B, 16, 1);
    load_list(tks_pkg::CMD_LOAD_C, 16, 1);
    repeat (160) send(tks_pkg::CMD_NEXT, '0);
    send(tks_pkg::CMD_CLEAR, '0);

    while (sent < 700) begin
      kind = $urandom_range(0, 2);
      na = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 18) : $urandom_range(1, 4);
      nb = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 18) : $urandom_range(1, 4);
      nc = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 18) : $urandom_range(1, 4);
      if ($urandom_range(0, 9) == 0) nc = 0;
      load_list(tks_pkg::CMD_LOAD_A, na, kind);
      if ($urandom_range(0, 7) == 0) send(tks_pkg::CMD_NEXT, '0);
      load_list(tks_pkg::CMD_LOAD_B, nb, kind);
      load_list(tks_pkg::CMD_LOAD_C, nc, kind);
      prod = (na > 16 ? 16 : na) * (nb > 16 ? 16 : nb) * (nc > 16 ? 16 : nc);
      nn = $urandom_range(1, 40);
      if (prod + 2 < nn) nn = prod + 2;
      repeat (nn) begin
        case ($urandom_range(0, 15))
          0: send(3'($urandom_range(5, 7)), rand_val(0));
          1: send(3'($urandom_range(0, 2)), rand_val(0));
          default: send(tks_pkg::CMD_NEXT, rand_val(0));
        endcase
      end
      if ($urandom_range(0, 2) == 0) drain();
      send(tks_pkg::CMD_CLEAR, rand_val(0));
    end

    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.due.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
